FILE: rtl/accel_tilt_roll_pitch_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt block
// Short forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ROLL_PITCH_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ATRP_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ATRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg
// Types, constants and the arctangent table of the tilt pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package atrp_pkg;

	localparam int DW         = 16;  // sample and result width
	localparam int VW         = 45;  // CORDIC vector width
	localparam int AW         = 36;  // angle width, 2^-24 degree units
	localparam int SQW        = 64;  // square root radicand width
	localparam int ANG_FRAC   = 24;
	localparam int ITERS      = 28;
	localparam int SQ_STEPS   = 32;
	localparam int NORM_STEPS = 7;
	localparam int NORM_EXP   = 40;
	localparam int WRW        = 33;  // wrapped angle width

	localparam logic signed [AW-1:0] DEG90  = AW'(90)  <<< ANG_FRAC;
	localparam logic signed [AW-1:0] DEG180 = AW'(180) <<< ANG_FRAC;
	localparam logic signed [AW-1:0] DEG360 = AW'(360) <<< ANG_FRAC;

	typedef enum logic [1:0] {
		BASE_0,
		BASE_P180,
		BASE_M180
	} base_t;

	typedef enum logic [2:0] {
		SP_NONE,
		SP_ZERO,
		SP_180,
		SP_P90,
		SP_M90
	} spec_t;

	typedef struct packed {
		logic signed [VW-1:0] num;
		logic signed [VW-1:0] den;
		logic signed [AW-1:0] acc;
		base_t                base;
		spec_t                spec;
	} vec_t;

	typedef struct packed {
		logic [SQW-1:0]       rem;
		logic [SQW-1:0]       root;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [DW-1:0] z;
	} sqrt_t;

	// atan(2^-i) in 2^-24 degree, rounded
	function automatic logic signed [AW-1:0] atan_val(input int i);
		logic signed [AW-1:0] v;
		case (i)
			0:  v = 36'sd754974720;
			1:  v = 36'sd445687602;
			2:  v = 36'sd235489088;
			3:  v = 36'sd119537938;
			4:  v = 36'sd60000934;
			5:  v = 36'sd30029717;
			6:  v = 36'sd15018523;
			7:  v = 36'sd7509720;
			8:  v = 36'sd3754917;
			9:  v = 36'sd1877466;
			10: v = 36'sd938734;
			11: v = 36'sd469367;
			12: v = 36'sd234684;
			13: v = 36'sd117342;
			14: v = 36'sd58671;
			15: v = 36'sd29335;
			16: v = 36'sd14668;
			17: v = 36'sd7334;
			18: v = 36'sd3667;
			19: v = 36'sd1833;
			20: v = 36'sd917;
			21: v = 36'sd458;
			22: v = 36'sd229;
			23: v = 36'sd115;
			24: v = 36'sd57;
			25: v = 36'sd29;
			26: v = 36'sd14;
			27: v = 36'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

	// normalize shifts: binary search, then one final doubling
	function automatic int norm_sh(input int i);
		int s;
		case (i)
			0: s = 32;
			1: s = 16;
			2: s = 8;
			3: s = 4;
			4: s = 2;
			default: s = 1;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/atrp_sample_if.sv
// ----------------------------------------------------------------------------
// atrp_sample_if
// Input channel: one three-axis accelerometer sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrp_sample_if import atrp_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] accel_x;
	logic signed [DW-1:0] accel_y;
	logic signed [DW-1:0] accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/atrp_result_if.sv
// ----------------------------------------------------------------------------
// atrp_result_if
// Output channel: roll and pitch in hundredths of a degree per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrp_result_if import atrp_pkg::*;;
	logic          valid;
	logic          ready;
	logic [DW-1:0] roll_centideg;
	logic [DW-1:0] pitch_centideg;

	modport source (output valid, roll_centideg, pitch_centideg, input ready);
	modport sink   (input valid, roll_centideg, pitch_centideg, output ready);
endinterface

`default_nettype wire

FILE: rtl/atrp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// atrp_sqrt_cell
// One digit of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_sqrt_cell import atrp_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic clk,
	input  wire logic en,
	input  sqrt_t     d,
	output sqrt_t     q
);

	localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * STEP);

	sqrt_t          nx;
	logic [SQW-1:0] trial;

	// try this root bit, keep it if the remainder allows
	always_comb begin
		nx    = d;
		trial = d.root + BIT;
		if (d.rem >= trial) begin
			nx.rem  = d.rem - trial;
			nx.root = (d.root >> 1) + BIT;
		end else begin
			nx.root = d.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end

endmodule

`default_nettype wire

FILE: rtl/atrp_norm_cell.sv
// ----------------------------------------------------------------------------
// atrp_norm_cell
// One normalize step: shifts the vector up by SH bits while it stays small, or always with FORCE.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_norm_cell import atrp_pkg::*; #(
	parameter int SH    = 1,
	parameter bit FORCE = 1'b0
) (
	input  wire logic clk,
	input  wire logic en,
	input  vec_t      d,
	output vec_t      q
);

	vec_t          nx;
	logic [VW-1:0] mag;
	logic          fit;

	// shift only if both components stay below 2^NORM_EXP afterward, or always when FORCE is set
	always_comb begin
		nx  = d;
		mag = d.num[VW-1] ? VW'(-d.num) : d.num;
		fit = ((mag >> (NORM_EXP - SH)) == '0) &&
		      ((VW'(d.den) >> (NORM_EXP - SH)) == '0);
		if (FORCE || fit) begin
			nx.num = d.num <<< SH;
			nx.den = d.den <<< SH;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end

endmodule

`default_nettype wire

FILE: rtl/atrp_cordic_cell.sv
// ----------------------------------------------------------------------------
// atrp_cordic_cell
// One vectoring CORDIC rotation with its angle update, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module atrp_cordic_cell import atrp_pkg::*; #(
	parameter int STEP = 0
) (
	input  wire logic clk,
	input  wire logic en,
	input  vec_t      d,
	output vec_t      q
);

	localparam logic signed [AW-1:0] ATAN = atan_val(STEP);

	vec_t                 nx;
	logic signed [VW-1:0] num;
	logic signed [VW-1:0] den;
	logic signed [VW-1:0] dn;
	logic signed [VW-1:0] dd;

	// rotate toward the x axis; sign of num picks the direction
	always_comb begin
		nx  = d;
		num = d.num;
		den = d.den;
		dn  = num >>> STEP;
		dd  = den >>> STEP;
		if (!num[VW-1]) begin
			nx.den = den + dn;
			nx.num = num - dd;
			nx.acc = d.acc + ATAN;
		end else begin
			nx.den = den - dn;
			nx.num = num + dd;
			nx.acc = d.acc - ATAN;
		end
	end

	always_ff @(posedge clk) begin
		if (en) q <= nx;
	end

endmodule

`default_nettype wire

FILE: rtl/accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from one accelerometer sample
// One item per cycle while the skid stage is empty; all stages hold while it is full.
// Built from 73 register stages, the first loaded at accept: input, radicand, 32 square
// root cells, vector build, 7 normalize and 28 CORDIC cells, wrap, scale, output.
// Output register with skid stage; ready drops only while the skid is full.
// arst_n clears all valid flags; payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_tilt_roll_pitch_macros.svh"

module accel_tilt_roll_pitch import atrp_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	atrp_sample_if.sink   sample,
	atrp_result_if.source result
);

	localparam int SX = DW - SAMPLE_BITS;

	logic en;

	// stage 1: sign-extended sample
	logic                 v_s1;
	logic signed [DW-1:0] x_s1, y_s1, z_s1;
	// stage 2: sum of squares
	logic                 v_s2;
	sqrt_t                sq_s2;
	logic signed [2*DW-1:0] yy, zz;
	// square root chain
	sqrt_t                sqc [SQ_STEPS];
	logic [SQ_STEPS-1:0]  sqv_q;
	// stage 3: vectors built
	logic                 v_s3;
	vec_t                 roll_s3, pitch_s3;
	// normalize and CORDIC chains
	vec_t                 nrc [NORM_STEPS];
	vec_t                 npc [NORM_STEPS];
	logic [NORM_STEPS-1:0] nv_q;
	vec_t                 crc [ITERS];
	vec_t                 cpc [ITERS];
	logic [ITERS-1:0]     cv_q;
	// stage 4: wrapped angles, stage 5: scaled results
	logic                 v_s4;
	logic [WRW-1:0]       rwrap_s4, pwrap_s4;
	logic                 v_s5;
	logic [DW-1:0]        roll_s5, pitch_s5;
	logic [WRW+7-1:0]     rprod, pprod;
	// output register and skid
	logic                 out_v_q, sk_v_q;
	logic [DW-1:0]        out_roll_q, out_pitch_q, sk_roll_q, sk_pitch_q;

	// build one vector: special cases, half-turn for a negative den
	function automatic vec_t vec_prep(input logic signed [VW-1:0] n,
	                                  input logic signed [VW-1:0] dv);
		vec_t v;
		v.num  = n;
		v.den  = dv;
		v.acc  = '0;
		v.base = BASE_0;
		v.spec = SP_NONE;
		if (n == '0) v.spec = dv[VW-1] ? SP_180 : SP_ZERO;
		else if (dv == '0) v.spec = n[VW-1] ? SP_M90 : SP_P90;
		if (dv[VW-1]) begin
			v.base = n[VW-1] ? BASE_M180 : BASE_P180;
			v.num  = -n;
			v.den  = -dv;
		end
		return v;
	endfunction

	// final angle, wrapped into [0, 360)
	function automatic logic [WRW-1:0] wrap_angle(input vec_t v);
		logic signed [AW-1:0] a;
		case (v.spec)
			SP_ZERO: a = '0;
			SP_180:  a = DEG180;
			SP_P90:  a = DEG90;
			SP_M90:  a = -DEG90;
			default: begin
				case (v.base)
					BASE_P180: a = v.acc + DEG180;
					BASE_M180: a = v.acc - DEG180;
					default:   a = v.acc;
				endcase
			end
		endcase
		if (a < 0) a = a + DEG360;
		if (a >= DEG360) a = a - DEG360;
		if (a < 0) a = '0;
		return a[WRW-1:0];
	endfunction

	assign en           = !sk_v_q;
	assign sample.ready = en;

	// valid flags of every stage before the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			sqv_q <= '0;
			v_s3  <= 1'b0;
			nv_q  <= '0;
			cv_q  <= '0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else if (en) begin
			v_s1  <= sample.valid;
			v_s2  <= v_s1;
			sqv_q <= {sqv_q[SQ_STEPS-2:0], v_s2};
			v_s3  <= sqv_q[SQ_STEPS-1];
			nv_q  <= {nv_q[NORM_STEPS-2:0], v_s3};
			cv_q  <= {cv_q[ITERS-2:0], nv_q[NORM_STEPS-1]};
			v_s4  <= cv_q[ITERS-1];
			v_s5  <= v_s4;
		end
	end

	// sample capture with sign extension from SAMPLE_BITS
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= (sample.accel_x <<< SX) >>> SX;
			y_s1 <= (sample.accel_y <<< SX) >>> SX;
			z_s1 <= (sample.accel_z <<< SX) >>> SX;
		end
	end

	// squares and radicand
	assign yy = y_s1 * y_s1;
	assign zz = z_s1 * z_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2.rem  <= {32'(yy) + 32'(zz), 32'd0};
			sq_s2.root <= '0;
			sq_s2.x    <= x_s1;
			sq_s2.y    <= y_s1;
			sq_s2.z    <= z_s1;
		end
	end

	// square root cell chain
	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		if (g == 0) begin : g_first
			atrp_sqrt_cell #(.STEP(g)) u_cell (
				.clk(clk), .en(en), .d(sq_s2), .q(sqc[g])
			);
		end else begin : g_next
			atrp_sqrt_cell #(.STEP(g)) u_cell (
				.clk(clk), .en(en), .d(sqc[g-1]), .q(sqc[g])
			);
		end
	end

	// roll uses (y, z); pitch uses (-x, root)
	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3  <= vec_prep(VW'(sqc[SQ_STEPS-1].y) <<< 16,
			                     VW'(sqc[SQ_STEPS-1].z) <<< 16);
			pitch_s3 <= vec_prep(-(VW'(sqc[SQ_STEPS-1].x) <<< 16),
			                     VW'({1'b0, sqc[SQ_STEPS-1].root[31:0]}));
		end
	end

	// normalize cell chain, roll and pitch lanes
	for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
		if (g == 0) begin : g_first
			atrp_norm_cell #(.SH(norm_sh(g)), .FORCE(1'b0)) u_roll (
				.clk(clk), .en(en), .d(roll_s3), .q(nrc[g])
			);
			atrp_norm_cell #(.SH(norm_sh(g)), .FORCE(1'b0)) u_pitch (
				.clk(clk), .en(en), .d(pitch_s3), .q(npc[g])
			);
		end else begin : g_next
			atrp_norm_cell #(.SH(norm_sh(g)), .FORCE(g == NORM_STEPS - 1)) u_roll (
				.clk(clk), .en(en), .d(nrc[g-1]), .q(nrc[g])
			);
			atrp_norm_cell #(.SH(norm_sh(g)), .FORCE(g == NORM_STEPS - 1)) u_pitch (
				.clk(clk), .en(en), .d(npc[g-1]), .q(npc[g])
			);
		end
	end

	// CORDIC cell chain, roll and pitch lanes
	for (genvar g = 0; g < ITERS; g++) begin : g_cordic
		if (g == 0) begin : g_first
			atrp_cordic_cell #(.STEP(g)) u_roll (
				.clk(clk), .en(en), .d(nrc[NORM_STEPS-1]), .q(crc[g])
			);
			atrp_cordic_cell #(.STEP(g)) u_pitch (
				.clk(clk), .en(en), .d(npc[NORM_STEPS-1]), .q(cpc[g])
			);
		end else begin : g_next
			atrp_cordic_cell #(.STEP(g)) u_roll (
				.clk(clk), .en(en), .d(crc[g-1]), .q(crc[g])
			);
			atrp_cordic_cell #(.STEP(g)) u_pitch (
				.clk(clk), .en(en), .d(cpc[g-1]), .q(cpc[g])
			);
		end
	end

	// angle select and wrap
	always_ff @(posedge clk) begin
		if (en) begin
			rwrap_s4 <= wrap_angle(crc[ITERS-1]);
			pwrap_s4 <= wrap_angle(cpc[ITERS-1]);
		end
	end

	// scale to hundredths of a degree, truncated
	assign rprod = (WRW + 7)'(rwrap_s4) * (WRW + 7)'(100);
	assign pprod = (WRW + 7)'(pwrap_s4) * (WRW + 7)'(100);

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s5  <= rprod[ANG_FRAC +: DW];
			pitch_s5 <= pprod[ANG_FRAC +: DW];
		end
	end

	// output register and skid stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (!out_v_q || result.ready) begin
			if (sk_v_q) begin
				out_v_q <= 1'b1;
				sk_v_q  <= 1'b0;
			end else begin
				out_v_q <= v_s5;
			end
		end else if (v_s5 && !sk_v_q) begin
			sk_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || result.ready) begin
			if (sk_v_q) begin
				out_roll_q  <= sk_roll_q;
				out_pitch_q <= sk_pitch_q;
			end else begin
				out_roll_q  <= roll_s5;
				out_pitch_q <= pitch_s5;
			end
		end else if (v_s5 && !sk_v_q) begin
			sk_roll_q  <= roll_s5;
			sk_pitch_q <= pitch_s5;
		end
	end

	assign result.valid          = out_v_q;
	assign result.roll_centideg  = out_roll_q;
	assign result.pitch_centideg = out_pitch_q;

	// checks
	`ATRP_ASSERT(a_skid_behind_out, sk_v_q, out_v_q, "skid holds an item with output empty")
	`ATRP_ASSERT(a_wrap_range, v_s4, (rwrap_s4 < WRW'(DEG360)) && (pwrap_s4 < WRW'(DEG360)), "wrapped angle out of range")
	`ATRP_ASSERT_NEXT(a_skid_catch, out_v_q && !result.ready && !sk_v_q && v_s5, sk_v_q, "stalled item not caught by skid")
	`ATRP_ASSERT(a_out_range, out_v_q, (out_roll_q < 16'd36000) && (out_pitch_q < 16'd36000), "result angle above 359.99")

endmodule

`default_nettype wire
